@@ design/ccl_pkg.sv @@
// Shared types, character codes and helper functions of the character-class table loader.
// No dependencies; imported by the top level and by its port checker.
`timescale 1ns / 1ps
`default_nettype none

package ccl_pkg;

    // Highest class number a definition may fill
    localparam int unsigned CLASS_COUNT = 8;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned ADDR_W      = 8;

    // Character codes used by the definition syntax
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_UP_N    = 8'h4E;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_UP_T    = 8'h54;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] CTRL_BIAS  = 8'h40;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_CHAR   = 2'd1,
        OP_END    = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    localparam logic [1:0] STAT_ACCEPT = 2'd0;
    localparam logic [1:0] STAT_DONE   = 2'd1;
    localparam logic [1:0] STAT_FAIL   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_A,
        ST_GAP,
        ST_RUN_B,
        ST_LOOK,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PM_NORMAL,
        PM_QUOTE,
        PM_CARET,
        PM_BSLASH,
        PM_OCTAL
    } mode_t;

    typedef enum logic [1:0] {
        RP_START,
        RP_NORMAL,
        RP_RANGE
    } phase_t;

    // What a pass over a span of table entries does to each entry
    typedef enum logic [1:0] {
        JK_MARK,     // set class member bit, primary class unless secondary
        JK_CLR_MEM,  // clear the class member bit
        JK_CLR_ALL,  // clear the class member bit and the primary class
        JK_ZERO      // write zero to both tables
    } job_kind_t;

    typedef struct packed {
        logic              vld;
        job_kind_t         kind;
        logic signed [8:0] lo;
        logic signed [8:0] hi;
        logic [3:0]        cls;
        logic              sec;
    } job_t;

    // Member bit of a class, none for class zero or classes above eight
    function automatic logic [7:0] class_bit(input logic [3:0] cls);
        logic [7:0] bits;
        bits = 8'd0;
        if (cls >= 4'd1 && cls <= 4'd8) begin
            bits = 8'd1 << (cls - 4'd1);
        end
        return bits;
    endfunction

    // Byte taken as a signed value
    function automatic logic signed [8:0] sbyte(input logic [7:0] b);
        return $signed({b[7], b});
    endfunction

endpackage

`default_nettype wire

@@ design/char_class_table_loader.sv @@
// Character-class table loader: top level, parser, sequencer and both table memories.
// Depends on ccl_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  transfer when          payload
//  s_        in         s_valid & s_ready      s_op, s_ch
//  m_        out        m_valid & m_ready      m_status, m_primary_class, m_member_mask
//  cfg_      in         cfg_wr_en              cfg_wr_data (first_class)
//
//  A lookup reads one entry; a definition character reads, modifies and writes back each table entry
//  it marks (a range marks its whole span, a character after an octal number adds a gap
//  state); begin and ',' sweep all 256 entries.
//  The table's single write port sets the pace: one entry is read, modified and written
//  back per cycle. After reset a clearing pass zeroes both tables; s_ready stays low
//  through it. A result waiting on m_ready does not block the next transfer.

module char_class_table_loader (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [7:0] s_ch,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic [3:0]      m_primary_class,
    output logic [7:0]      m_member_mask
);
    import ccl_pkg::*;

    // ---------------------------------------------------------------- state
    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        rs_reg, rs_next;          // range start
    logic [7:0]        oct_reg, oct_next;        // pending octal value
    logic              sec_reg, sec_next;        // secondary members
    logic [3:0]        cc_reg, cc_next;          // current class, zero when closed
    logic              failed_reg, failed_next;
    logic [3:0]        first_class_reg;
    logic              init_reg;                 // reset clearing pass in progress

    job_t              job_a_reg, job_b_reg, job_a_next, job_b_next;
    logic signed [8:0] cur_reg;                  // sweep cursor
    logic [1:0]        res_status_reg, res_status_next;
    logic [3:0]        res_pc_reg;
    logic [7:0]        res_mm_reg;

    // Write-back stage of the read-modify-write
    logic              wr_vld_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    job_t              wr_job_reg;

    // Output register
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [3:0]        m_pc_reg;
    logic [7:0]        m_mm_reg;

    // Table memories and their registered read data
    logic [3:0]        pri_mem [TABLE_DEPTH];
    logic [7:0]        mbr_mem [TABLE_DEPTH];
    logic [3:0]        pri_q_reg;
    logic [7:0]        mbr_q_reg;

    // Sequencer controls
    logic              accept;
    logic              is_lookup;
    job_t              act_job;
    logic              issue;
    logic              last;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
    logic [3:0]        wr_pri;
    logic [7:0]        wr_mbr;

    assign accept    = s_valid && s_ready;
    assign is_lookup = (op_t'(s_op) == OP_LOOKUP);

    // ---------------------------------------------------------------- parser
    // Work out the new parser state and up to two passes over the table for one item.
    always_comb begin
        logic       ap1_en;
        logic [7:0] ap1_v;
        logic       pl_en;
        logic       ap2_en;
        logic [7:0] ap2_v;
        phase_t     ph1;
        logic [7:0] rs1;
        logic [7:0] up;
        logic       dig;
        logic [4:0] nxt_cls;
        logic [3:0] fc;

        ap1_en  = 1'b0;
        ap1_v   = 8'd0;
        pl_en   = 1'b0;
        ap2_en  = 1'b0;
        ap2_v   = 8'd0;
        ph1     = phase_reg;
        rs1     = rs_reg;
        dig     = (s_ch >= CH_ZERO) && (s_ch <= CH_NINE);
        up      = ((s_ch >= CH_LOW_A) && (s_ch <= CH_LOW_Z)) ? (s_ch - CASE_GAP) : s_ch;
        nxt_cls = {1'b0, cc_reg} + 5'd1;
        fc      = (first_class_reg == 4'd0) ? 4'd1 : first_class_reg;

        mode_next       = mode_reg;
        phase_next      = phase_reg;
        rs_next         = rs_reg;
        oct_next        = oct_reg;
        sec_next        = sec_reg;
        cc_next         = cc_reg;
        failed_next     = failed_reg;
        res_status_next = STAT_ACCEPT;
        job_a_next      = '0;
        job_b_next      = '0;

        case (op_t'(s_op))
            OP_BEGIN: begin
                cc_next     = fc;
                failed_next = (fc > 4'(CLASS_COUNT));
                oct_next    = 8'd0;
                rs_next     = 8'd0;
                phase_next  = RP_START;
                sec_next    = 1'b0;
                mode_next   = PM_NORMAL;
                // clear every primary entry; member bit only for a class that starts
                job_b_next.vld  = 1'b1;
                job_b_next.kind = JK_CLR_ALL;
                job_b_next.lo   = 9'sd0;
                job_b_next.hi   = 9'sd255;
                job_b_next.cls  = (fc > 4'(CLASS_COUNT)) ? 4'd0 : fc;
            end
            OP_CHAR: begin
                if (cc_reg != 4'd0 && !failed_reg) begin
                    case (mode_reg)
                        PM_QUOTE: begin
                            mode_next = PM_NORMAL;
                            if (s_ch == CH_QUOTE) begin
                                ap1_en = 1'b1;
                                ap1_v  = CH_QUOTE;
                            end else begin
                                pl_en = 1'b1;
                            end
                        end
                        PM_CARET: begin
                            mode_next = PM_NORMAL;
                            ap1_en    = 1'b1;
                            ap1_v     = up - CTRL_BIAS;
                        end
                        PM_BSLASH: begin
                            if (dig) begin
                                oct_next  = s_ch - CH_ZERO;
                                mode_next = PM_OCTAL;
                            end else begin
                                mode_next = PM_NORMAL;
                                ap1_en    = 1'b1;
                                if (s_ch == CH_LOW_N || s_ch == CH_UP_N) begin
                                    ap1_v = CH_NEWLINE;
                                end else if (s_ch == CH_LOW_T || s_ch == CH_UP_T) begin
                                    ap1_v = CH_TAB;
                                end else begin
                                    ap1_v = s_ch;
                                end
                            end
                        end
                        PM_OCTAL: begin
                            if (dig) begin
                                oct_next = {oct_reg[4:0], 3'b000} + (s_ch - CH_ZERO);
                            end else begin
                                mode_next = PM_NORMAL;
                                ap1_en    = 1'b1;
                                ap1_v     = oct_reg;
                                pl_en     = 1'b1;
                            end
                        end
                        default: begin
                            mode_next = PM_NORMAL;
                            pl_en     = 1'b1;
                        end
                    endcase
                end
            end
            OP_END: begin
                if (cc_reg != 4'd0 && !failed_reg && mode_reg == PM_OCTAL) begin
                    ap1_en = 1'b1;
                    ap1_v  = oct_reg;
                end
                mode_next       = PM_NORMAL;
                cc_next         = 4'd0;
                res_status_next = failed_reg ? STAT_FAIL : STAT_DONE;
            end
            default: begin
            end
        endcase

        // first character taken into the class
        if (ap1_en) begin
            job_a_next.vld  = 1'b1;
            job_a_next.kind = JK_MARK;
            job_a_next.lo   = (ph1 == RP_RANGE) ? sbyte(rs1) : sbyte(ap1_v);
            job_a_next.hi   = sbyte(ap1_v);
            job_a_next.cls  = cc_reg;
            job_a_next.sec  = sec_reg;
            rs1             = ap1_v;
            ph1             = RP_NORMAL;
        end

        // the item's own character outside any escape
        if (pl_en) begin
            case (s_ch)
                CH_COMMA: begin
                    if (nxt_cls > 5'(CLASS_COUNT)) begin
                        failed_next = 1'b1;
                        mode_next   = PM_NORMAL;
                    end else begin
                        cc_next         = nxt_cls[3:0];
                        job_b_next.vld  = 1'b1;
                        job_b_next.kind = JK_CLR_MEM;
                        job_b_next.lo   = 9'sd0;
                        job_b_next.hi   = 9'sd255;
                        job_b_next.cls  = nxt_cls[3:0];
                        ph1             = RP_START;
                        sec_next        = 1'b0;
                        mode_next       = PM_NORMAL;
                    end
                end
                CH_QUOTE:  mode_next = PM_QUOTE;
                CH_DASH: begin
                    if (ph1 == RP_NORMAL) begin
                        ph1 = RP_RANGE;
                    end else begin
                        ap2_en = 1'b1;
                        ap2_v  = CH_DASH;
                    end
                end
                CH_TILDE:  sec_next  = 1'b1;
                CH_CARET:  mode_next = PM_CARET;
                CH_BSLASH: mode_next = PM_BSLASH;
                default: begin
                    ap2_en = 1'b1;
                    ap2_v  = s_ch;
                end
            endcase
        end

        if (ap2_en) begin
            job_b_next.vld  = 1'b1;
            job_b_next.kind = JK_MARK;
            job_b_next.lo   = (ph1 == RP_RANGE) ? sbyte(rs1) : sbyte(ap2_v);
            job_b_next.hi   = sbyte(ap2_v);
            job_b_next.cls  = cc_reg;
            job_b_next.sec  = sec_reg;
            rs1             = ap2_v;
            ph1             = RP_NORMAL;
        end

        if (op_t'(s_op) == OP_CHAR || op_t'(s_op) == OP_END) begin
            phase_next = ph1;
            rs_next    = rs1;
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign act_job = (state_reg == ST_RUN_B) ? job_b_reg : job_a_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_lookup) begin
                        state_next = ST_LOOK;
                    end else if (job_a_next.vld) begin
                        state_next = ST_RUN_A;
                    end else if (job_b_next.vld) begin
                        state_next = ST_RUN_B;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN_A: begin
                if (last) begin
                    if (job_b_reg.vld) begin
                        state_next = ST_GAP;
                    end else if (init_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_GAP:   state_next = ST_RUN_B;
            ST_RUN_B: begin
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_LOOK:  state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        last     = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = !wr_vld_reg;
            ST_RUN_A, ST_RUN_B: begin
                // an empty range finishes at once
                issue = (cur_reg <= act_job.hi);
                last  = (cur_reg >= act_job.hi);
            end
            ST_DONE: out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    assign rd_en   = issue || (accept && is_lookup);
    assign rd_addr = issue ? cur_reg[ADDR_W-1:0] : s_ch;

    // Modify step of the read-modify-write
    always_comb begin
        wr_pri = pri_q_reg;
        wr_mbr = mbr_q_reg;
        case (wr_job_reg.kind)
            JK_MARK: begin
                wr_mbr = mbr_q_reg | class_bit(wr_job_reg.cls);
                if (!wr_job_reg.sec) begin
                    wr_pri = wr_job_reg.cls;
                end
            end
            JK_CLR_MEM: wr_mbr = mbr_q_reg & ~class_bit(wr_job_reg.cls);
            JK_CLR_ALL: begin
                wr_mbr = mbr_q_reg & ~class_bit(wr_job_reg.cls);
                wr_pri = 4'd0;
            end
            JK_ZERO: begin
                wr_mbr = 8'd0;
                wr_pri = 4'd0;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- memories
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pri_q_reg <= pri_mem[rd_addr];
            mbr_q_reg <= mbr_mem[rd_addr];
        end
        if (wr_vld_reg) begin
            pri_mem[wr_addr_reg] <= wr_pri;
            mbr_mem[wr_addr_reg] <= wr_mbr;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_RUN_A;
            init_reg        <= 1'b1;
            job_a_reg       <= '{vld: 1'b1, kind: JK_ZERO, lo: 9'sd0, hi: 9'sd255,
                                 cls: 4'd0, sec: 1'b0};
            job_b_reg       <= '0;
            cur_reg         <= 9'sd0;
            wr_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            mode_reg        <= PM_NORMAL;
            phase_reg       <= RP_START;
            rs_reg          <= 8'd0;
            oct_reg         <= 8'd0;
            sec_reg         <= 1'b0;
            cc_reg          <= 4'd0;
            failed_reg      <= 1'b0;
            first_class_reg <= 4'd1;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                first_class_reg <= cfg_wr_data;
            end

            if (accept) begin
                mode_reg   <= mode_next;
                phase_reg  <= phase_next;
                rs_reg     <= rs_next;
                oct_reg    <= oct_next;
                sec_reg    <= sec_next;
                cc_reg     <= cc_next;
                failed_reg <= failed_next;
                job_a_reg  <= job_a_next;
                job_b_reg  <= job_b_next;
                cur_reg    <= job_a_next.vld ? job_a_next.lo : job_b_next.lo;
            end else if (issue) begin
                cur_reg <= cur_reg + 9'sd1;
            end else if (state_reg == ST_GAP) begin
                cur_reg <= job_b_reg.lo;
            end

            // the clearing pass ends with the first pass of the sequencer
            if (state_reg == ST_RUN_A && last) begin
                init_reg <= 1'b0;
            end

            wr_vld_reg <= issue;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (issue) begin
            wr_addr_reg <= cur_reg[ADDR_W-1:0];
            wr_job_reg  <= act_job;
        end
        if (accept) begin
            res_status_reg <= res_status_next;
            res_pc_reg     <= 4'd0;
            res_mm_reg     <= 8'd0;
        end else if (state_reg == ST_LOOK) begin
            res_pc_reg <= pri_q_reg;
            res_mm_reg <= mbr_q_reg;
        end
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_pc_reg     <= res_pc_reg;
            m_mm_reg     <= res_mm_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_primary_class = m_pc_reg;
    assign m_member_mask   = m_mm_reg;

endmodule

`default_nettype wire

@@ design/ccl_checker.sv @@
// Port-level checks of the character-class table loader and their bind to the top level.
// Depends on ccl_pkg and char_class_table_loader.
`timescale 1ns / 1ps
`default_nettype none

module ccl_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_status,
    input wire logic [3:0] m_primary_class,
    input wire logic [7:0] m_member_mask
);
    import ccl_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_primary_class) && $stable(m_member_mask))
        else $error("stalled result changed");

    // the clearing pass keeps the input closed after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open straight after reset");

    // one item at a time: no transfer in the cycle after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer without processing");

    // only a lookup carries table data, and it never names a class past the limit
    a_status_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_ACCEPT |-> m_primary_class == 4'd0 &&
        m_member_mask == 8'd0 && (m_status == STAT_DONE || m_status == STAT_FAIL))
        else $error("finish status with table data");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_primary_class <= 4'(CLASS_COUNT))
        else $error("primary class above limit");

endmodule

bind char_class_table_loader ccl_checker u_ccl_checker (.*);

`default_nettype wire
